>>> rtl/xsvf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xsvf_pkg
// Shared opcodes, parse phases and decode types for the XSVF framer.
// ----------------------------------------------------------------------------
package xsvf_pkg;

    localparam int unsigned MAX_VECTOR_BYTES = 8192;
    localparam int unsigned CNT_W            = 14;

    localparam logic [7:0] OP_XCOMPLETE    = 8'h00;
    localparam logic [7:0] OP_XTDOMASK     = 8'h01;
    localparam logic [7:0] OP_XSIR         = 8'h02;
    localparam logic [7:0] OP_XSDR         = 8'h03;
    localparam logic [7:0] OP_XRUNTEST     = 8'h04;
    localparam logic [7:0] OP_XREPEAT      = 8'h07;
    localparam logic [7:0] OP_XSDRSIZE     = 8'h08;
    localparam logic [7:0] OP_XSDRTDO      = 8'h09;
    localparam logic [7:0] OP_XSETSDRMASKS = 8'h0A;
    localparam logic [7:0] OP_XSDRB        = 8'h0C;
    localparam logic [7:0] OP_XSDRC        = 8'h0D;
    localparam logic [7:0] OP_XSDRE        = 8'h0E;
    localparam logic [7:0] OP_XSDRTDOB     = 8'h0F;
    localparam logic [7:0] OP_XSDRTDOC     = 8'h10;
    localparam logic [7:0] OP_XSDRTDOE     = 8'h11;
    localparam logic [7:0] OP_XSTATE       = 8'h12;

    localparam logic [1:0] ROLE_OPCODE = 2'd0;
    localparam logic [1:0] ROLE_PARAM  = 2'd1;
    localparam logic [1:0] ROLE_VEC1   = 2'd2;
    localparam logic [1:0] ROLE_VEC2   = 2'd3;

    typedef enum logic [4:0] {
        PH_OPCODE = 5'b00001,
        PH_PARAM  = 5'b00010,
        PH_VEC1   = 5'b00100,
        PH_VEC2   = 5'b01000,
        PH_IRLEN  = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        K_COMPLETE,
        K_PARAM1,
        K_PARAM4,
        K_XSIR,
        K_ONE_VEC,
        K_TWO_VEC,
        K_OTHER
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     is_ping;
    } op_dec_t;

endpackage
`default_nettype wire

>>> rtl/xsvf_opdec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xsvf_opdec
// Classifies an opcode byte by the shape of its payload.
// ----------------------------------------------------------------------------
module xsvf_opdec (
    input  wire logic             [7:0] opcode,
    input  wire logic             [7:0] ping_opcode,
    output xsvf_pkg::op_dec_t           dec
);

    always_comb
    begin
        dec.is_ping = (opcode == ping_opcode);
        unique case (opcode)
            xsvf_pkg::OP_XCOMPLETE:    dec.kind = xsvf_pkg::K_COMPLETE;
            xsvf_pkg::OP_XREPEAT,
            xsvf_pkg::OP_XSTATE:       dec.kind = xsvf_pkg::K_PARAM1;
            xsvf_pkg::OP_XRUNTEST,
            xsvf_pkg::OP_XSDRSIZE:     dec.kind = xsvf_pkg::K_PARAM4;
            xsvf_pkg::OP_XSIR:         dec.kind = xsvf_pkg::K_XSIR;
            xsvf_pkg::OP_XTDOMASK,
            xsvf_pkg::OP_XSDR,
            xsvf_pkg::OP_XSDRB,
            xsvf_pkg::OP_XSDRC,
            xsvf_pkg::OP_XSDRE:        dec.kind = xsvf_pkg::K_ONE_VEC;
            xsvf_pkg::OP_XSDRTDO,
            xsvf_pkg::OP_XSDRTDOB,
            xsvf_pkg::OP_XSDRTDOC,
            xsvf_pkg::OP_XSDRTDOE,
            xsvf_pkg::OP_XSETSDRMASKS: dec.kind = xsvf_pkg::K_TWO_VEC;
            // XSDRINC and unused codes
            default:                   dec.kind = xsvf_pkg::K_OTHER;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/xsvf_instruction_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xsvf_instruction_framer
// Tags each byte of an XSVF stream with its role and marks instruction ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one stream byte per beat. Output
//   channel out_valid/out_ready carries one tagged beat per input beat, in
//   order: the byte, its role, an end-of-instruction mark and a bad-opcode
//   flag.
//   A byte is registered as it is taken and presented in the cycle after.
//   Throughput is one byte per cycle unless stalled; the parse state is updated
//   in a single pass between the state registers and the output register.
//   The output register decouples the sides: a new byte is taken whenever
//   the register is empty or its beat is being taken in the same cycle. If
//   the receiver stalls with the register full, in_ready drops and the
//   parse state holds.
//   cfg_write/cfg_data load the ping opcode; write only while idle.
//   Reset clears the parse state to expect an opcode, empties the output
//   register and sets the ping opcode to 8'hFF.
// ----------------------------------------------------------------------------
module xsvf_instruction_framer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte,
    output logic      [1:0] byte_role,
    output logic            last_of_instr,
    output logic            bad_opcode
);

    localparam int unsigned CW = xsvf_pkg::CNT_W;

    logic [7:0]          ping_reg;
    xsvf_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]          opcode_reg, opcode_next;
    logic [CW-1:0]       left_reg, left_next;
    logic [1:0]          vecs_reg, vecs_next;
    logic [CW-1:0]       vcount_reg, vcount_next;
    logic [7:0]          size_hi_reg, size_hi_next;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic [1:0]          role_reg, role_next;
    logic                last_reg, last_next;
    logic                bad_reg, bad_next;

    xsvf_pkg::op_dec_t   dec;
    logic                take;
    logic [CW-1:0]       left_dec;
    logic [1:0]          vecs_dec;
    logic [16:0]         size_sum;
    logic [CW-1:0]       size_bytes;
    logic [8:0]          ir_sum;
    logic [CW-1:0]       ir_bytes;

    xsvf_opdec u_opdec (
        .opcode      (in_byte),
        .ping_opcode (ping_reg),
        .dec         (dec)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign left_dec = left_reg - CW'(1);
    assign vecs_dec = vecs_reg - 2'd1;
    assign size_sum = {1'b0, size_hi_reg, in_byte} + 17'd7;
    // ceil(bits/8) of a 16-bit size never exceeds the cap, but keep it
    assign size_bytes = (size_sum[16:3] > CW'(xsvf_pkg::MAX_VECTOR_BYTES))
                      ? CW'(xsvf_pkg::MAX_VECTOR_BYTES) : size_sum[16:3];
    assign ir_sum   = {1'b0, in_byte} + 9'd7;
    assign ir_bytes = CW'(ir_sum[8:3]);

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        left_next    = left_reg;
        vecs_next    = vecs_reg;
        vcount_next  = vcount_reg;
        size_hi_next = size_hi_reg;
        role_next    = xsvf_pkg::ROLE_OPCODE;
        last_next    = 1'b0;
        bad_next     = 1'b0;

        unique case (phase_reg)
            xsvf_pkg::PH_PARAM:
            begin
                role_next = xsvf_pkg::ROLE_PARAM;
                if (opcode_reg == xsvf_pkg::OP_XSDRSIZE)
                begin
                    if (left_reg == CW'(2))
                        size_hi_next = in_byte;
                    else if (left_reg == CW'(1))
                        vcount_next = size_bytes;
                end
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    last_next  = 1'b1;
                    phase_next = xsvf_pkg::PH_OPCODE;
                end
            end
            xsvf_pkg::PH_IRLEN:
            begin
                role_next = xsvf_pkg::ROLE_PARAM;
                if (ir_bytes == '0)
                begin
                    phase_next = xsvf_pkg::PH_OPCODE;
                    left_next  = '0;
                    vecs_next  = 2'd0;
                    last_next  = 1'b1;
                end
                else
                begin
                    phase_next = xsvf_pkg::PH_VEC1;
                    left_next  = ir_bytes;
                    vecs_next  = 2'd1;
                end
            end
            xsvf_pkg::PH_VEC1,
            xsvf_pkg::PH_VEC2:
            begin
                role_next = (phase_reg == xsvf_pkg::PH_VEC1)
                          ? xsvf_pkg::ROLE_VEC1 : xsvf_pkg::ROLE_VEC2;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    if (vecs_dec != 2'd0 && vcount_reg != '0)
                    begin
                        vecs_next  = vecs_dec;
                        phase_next = xsvf_pkg::PH_VEC2;
                        left_next  = vcount_reg;
                    end
                    else
                    begin
                        vecs_next  = 2'd0;
                        phase_next = xsvf_pkg::PH_OPCODE;
                        last_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                opcode_next = in_byte;
                unique case (dec.kind)
                    xsvf_pkg::K_COMPLETE:
                        last_next = 1'b1;
                    xsvf_pkg::K_PARAM1:
                    begin
                        phase_next = xsvf_pkg::PH_PARAM;
                        left_next  = CW'(1);
                    end
                    xsvf_pkg::K_PARAM4:
                    begin
                        phase_next = xsvf_pkg::PH_PARAM;
                        left_next  = CW'(4);
                    end
                    xsvf_pkg::K_XSIR:
                        phase_next = xsvf_pkg::PH_IRLEN;
                    xsvf_pkg::K_ONE_VEC,
                    xsvf_pkg::K_TWO_VEC:
                    begin
                        if (vcount_reg == '0)
                        begin
                            phase_next = xsvf_pkg::PH_OPCODE;
                            left_next  = '0;
                            vecs_next  = 2'd0;
                            last_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next = xsvf_pkg::PH_VEC1;
                            left_next  = vcount_reg;
                            vecs_next  = (dec.kind == xsvf_pkg::K_TWO_VEC) ? 2'd2 : 2'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = xsvf_pkg::PH_OPCODE;
                        last_next  = 1'b1;
                        bad_next   = !dec.is_ping;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_reg      <= 8'hFF;
            phase_reg     <= xsvf_pkg::PH_OPCODE;
            opcode_reg    <= '0;
            left_reg      <= '0;
            vecs_reg      <= '0;
            vcount_reg    <= '0;
            size_hi_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                ping_reg <= cfg_data;
            if (take)
            begin
                phase_reg   <= phase_next;
                opcode_reg  <= opcode_next;
                left_reg    <= left_next;
                vecs_reg    <= vecs_next;
                vcount_reg  <= vcount_next;
                size_hi_reg <= size_hi_next;
            end
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= in_byte;
            role_reg     <= role_next;
            last_reg     <= last_next;
            bad_reg      <= bad_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_role     = role_reg;
    assign last_of_instr = last_reg;
    assign bad_opcode    = bad_reg;

endmodule
`default_nettype wire

>>> bench/xsvf_frame_checker.sv
// ----------------------------------------------------------------------------
// xsvf_frame_checker
// Watches both channels of the framer, works out the tag of every byte taken
// and checks each output beat against it, oldest first. Hands the mismatch
// count and the number of beats still due to the test top.
// ----------------------------------------------------------------------------
module xsvf_frame_checker
    import xsvf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic [1:0]  byte_role,
    input  logic        last_of_instr,
    input  logic        bad_opcode,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    localparam logic [7:0] PING_RESET  = 8'hFF;
    localparam int unsigned PRINT_LIMIT = 200;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] role;
        logic       last;
        logic       bad;
    } framed_beat_t;

    framed_beat_t expected_beats [$];
    int unsigned  beat_no;

    // shadow of the framer's parse state
    phase_t      phase;
    logic [7:0]  ping;
    logic [7:0]  cur_op;
    logic [7:0]  size_hi;
    logic [13:0] left;
    logic [13:0] vec_count;
    logic [1:0]  vec_left;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatches < PRINT_LIMIT)
            $display("frame check: beat %0d %s: expected %0h, got %0h",
                     beat_no, what, want, got);
        mismatches++;
    endtask

    // returns 1 when there is nothing to shift and the instruction is done
    function automatic logic open_vectors(input logic [13:0] count,
                                          input logic [1:0] nvec);
        if (count == 14'd0) begin
            phase    = PH_OPCODE;
            left     = 14'd0;
            vec_left = 2'd0;
            return 1'b1;
        end
        phase    = PH_VEC1;
        left     = count;
        vec_left = nvec;
        return 1'b0;
    endfunction

    function automatic framed_beat_t frame_next(input logic [7:0] b);
        framed_beat_t beat;
        int unsigned  bits;
        int unsigned  count;
        beat.data = b;
        beat.role = ROLE_OPCODE;
        beat.last = 1'b0;
        beat.bad  = 1'b0;
        case (phase)
            PH_PARAM:
            begin
                beat.role = ROLE_PARAM;
                if (cur_op == OP_XSDRSIZE) begin
                    // only the low half of the 32-bit size counts
                    if (left == 14'd2) begin
                        size_hi = b;
                    end else if (left == 14'd1) begin
                        bits  = 32'({size_hi, b});
                        count = (bits + 7) >> 3;
                        if (count > MAX_VECTOR_BYTES)
                            count = MAX_VECTOR_BYTES;
                        vec_count = count[13:0];
                    end
                end
                left = left - 14'd1;
                if (left == 14'd0) begin
                    beat.last = 1'b1;
                    phase     = PH_OPCODE;
                end
            end
            PH_IRLEN:
            begin
                beat.role = ROLE_PARAM;
                bits      = 32'(b);
                count     = (bits + 7) >> 3;
                beat.last = open_vectors(count[13:0], 2'd1);
            end
            PH_VEC1, PH_VEC2:
            begin
                beat.role = (phase == PH_VEC1) ? ROLE_VEC1 : ROLE_VEC2;
                left      = left - 14'd1;
                if (left == 14'd0) begin
                    vec_left = vec_left - 2'd1;
                    if (vec_left != 2'd0 && vec_count != 14'd0) begin
                        phase = PH_VEC2;
                        left  = vec_count;
                    end else begin
                        vec_left  = 2'd0;
                        phase     = PH_OPCODE;
                        beat.last = 1'b1;
                    end
                end
            end
            default:
            begin
                cur_op = b;
                case (b)
                    OP_XCOMPLETE:
                        beat.last = 1'b1;
                    OP_XREPEAT, OP_XSTATE:
                    begin
                        phase = PH_PARAM;
                        left  = 14'd1;
                    end
                    OP_XRUNTEST, OP_XSDRSIZE:
                    begin
                        phase = PH_PARAM;
                        left  = 14'd4;
                    end
                    OP_XSIR:
                        phase = PH_IRLEN;
                    OP_XTDOMASK, OP_XSDR, OP_XSDRB, OP_XSDRC, OP_XSDRE:
                        beat.last = open_vectors(vec_count, 2'd1);
                    OP_XSDRTDO, OP_XSDRTDOB, OP_XSDRTDOC, OP_XSDRTDOE,
                    OP_XSETSDRMASKS:
                        beat.last = open_vectors(vec_count, 2'd2);
                    default:
                    begin
                        // standard codes win over the ping value
                        phase     = PH_OPCODE;
                        beat.last = 1'b1;
                        beat.bad  = (b != ping);
                    end
                endcase
            end
        endcase
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : sample_edge
        framed_beat_t want;
        if (!rst_n) begin
            expected_beats.delete();
            beat_no     = 0;
            mismatches  = 0;
            outstanding <= 0;
            phase       = PH_OPCODE;
            ping        = PING_RESET;
            cur_op      = 8'd0;
            size_hi     = 8'd0;
            left        = 14'd0;
            vec_count   = 14'd0;
            vec_left    = 2'd0;
        end else begin
            // the output is registered behind the input, so compare before queueing
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing due", 8'd0, out_byte);
                end else begin
                    want = expected_beats.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", want.data, out_byte);
                    if (byte_role !== want.role)
                        report_mismatch("byte_role", 8'(want.role), 8'(byte_role));
                    if (last_of_instr !== want.last)
                        report_mismatch("last_of_instr", 8'(want.last),
                                        8'(last_of_instr));
                    if (bad_opcode !== want.bad)
                        report_mismatch("bad_opcode", 8'(want.bad), 8'(bad_opcode));
                end
                beat_no++;
            end
            if (in_valid && in_ready)
                expected_beats.push_back(frame_next(in_byte));
            // a byte taken at the same edge still sees the old ping
            if (cfg_write)
                ping = cfg_data;
            outstanding <= expected_beats.size();
        end
    end

endmodule

>>> bench/xsvf_instruction_framer_test.sv
// ----------------------------------------------------------------------------
// xsvf_instruction_framer_test
// Feeds the framer a short hand-made stream, then random well-formed XSVF
// instructions with random payloads and some stray opcodes, under several
// ping settings, and ends with the head of a maximum-length vector. Both
// sides stall at random; the frame checker alongside decides pass or fail.
// ----------------------------------------------------------------------------
module xsvf_instruction_framer_test;
    import xsvf_pkg::*;

    localparam logic [7:0]  OP_XSDRINC       = 8'h0B;
    localparam logic [7:0]  OP_UNUSED_05     = 8'h05;
    localparam logic [7:0]  OP_UNUSED_06     = 8'h06;
    localparam logic [7:0]  OP_UNDEFINED_LO  = 8'h13;
    localparam logic [7:0]  OP_UNDEFINED_FE  = 8'hFE;
    localparam logic [7:0]  PING_RESET       = 8'hFF;
    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned BYTES_PER_PHASE  = 90;
    localparam int unsigned LONG_HOLD        = 64;
    localparam int unsigned IDLE_LIMIT       = 3000;
    localparam int unsigned MAX_VEC_HEAD     = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_role;
    logic        last_of_instr;
    logic        bad_opcode;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned vec_bytes = 0;
    logic [7:0]  ping_now = PING_RESET;
    bit          long_hold_due = 1'b0;

    always #1 clk = ~clk;

    xsvf_instruction_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_role     (byte_role),
        .last_of_instr (last_of_instr),
        .bad_opcode    (bad_opcode)
    );

    xsvf_frame_checker frame_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_role     (byte_role),
        .last_of_instr (last_of_instr),
        .bad_opcode    (bad_opcode),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_size_bits();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 80)
            return 16'($urandom_range(1, 48));
        if (r < 95)
            return 16'($urandom_range(49, 300));
        return {6'd0, 2'($urandom_range(1, 3)), 8'($urandom)};
    endfunction

    function automatic int unsigned pick_ir_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 9)
            return $urandom_range(0, 255);
        return $urandom_range(1, 40);
    endfunction

    function automatic logic [7:0] pick_opcode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OP_XCOMPLETE;
        if (r < 12)
            return ($urandom_range(0, 1) != 0) ? OP_XREPEAT : OP_XSTATE;
        if (r < 18)
            return OP_XRUNTEST;
        if (r < 30)
            return OP_XSDRSIZE;
        if (r < 40)
            return OP_XSIR;
        if (r < 60) begin
            case ($urandom_range(0, 4))
                0:       return OP_XTDOMASK;
                1:       return OP_XSDR;
                2:       return OP_XSDRB;
                3:       return OP_XSDRC;
                default: return OP_XSDRE;
            endcase
        end
        if (r < 78) begin
            case ($urandom_range(0, 4))
                0:       return OP_XSDRTDO;
                1:       return OP_XSETSDRMASKS;
                2:       return OP_XSDRTDOB;
                3:       return OP_XSDRTDOC;
                default: return OP_XSDRTDOE;
            endcase
        end
        if (r < 84)
            return ping_now;
        if (r < 91) begin
            case ($urandom_range(0, 3))
                0:       return OP_XSDRINC;
                1:       return OP_UNUSED_05;
                2:       return OP_UNUSED_06;
                default: return 8'($urandom_range(OP_UNDEFINED_LO, 8'hFF));
            endcase
        end
        // stray byte in opcode position
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        if (burst_left != 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 31) == 0)
                burst_left = $urandom_range(10, 40);
        end
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        bytes_sent++;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_byte(8'($urandom));
    endtask

    // opcode plus the payload the stream format calls for
    task automatic send_instruction(input logic [7:0] op);
        logic [15:0] bits;
        int unsigned ir_len;
        send_byte(op);
        case (op)
            OP_XREPEAT, OP_XSTATE:
                send_random(1);
            OP_XRUNTEST:
                send_random(4);
            OP_XSDRSIZE:
            begin
                bits = pick_size_bits();
                send_random(2);
                send_byte(bits[15:8]);
                send_byte(bits[7:0]);
                vec_bytes = (int'(bits) + 7) / 8;
            end
            OP_XSIR:
            begin
                ir_len = pick_ir_len();
                send_byte(8'(ir_len));
                send_random((ir_len + 7) / 8);
            end
            OP_XTDOMASK, OP_XSDR, OP_XSDRB, OP_XSDRC, OP_XSDRE:
                send_random(vec_bytes);
            OP_XSDRTDO, OP_XSETSDRMASKS, OP_XSDRTDOB, OP_XSDRTDOC, OP_XSDRTDOE:
                send_random(2 * vec_bytes);
            default:
                ;
        endcase
    endtask

    // drop valid, let every due beat come out, then allow for the latency
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_ping(input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // receiver: random stalls and ready runs, plus one long hold on request
    initial
    begin
        int unsigned stall;
        int unsigned run;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = pick_gap();
            run   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall         = LONG_HOLD;
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat (run) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("xsvf_instruction_framer_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0]  opening [$];
        logic [7:0]  ping_plan [$];
        int unsigned phase_end;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        in_byte   = 8'd0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // hand-made opening with the ping still at its reset value: complete,
        // ping, unknown, XSDRINC, empty vectors, zero-length XSIR, a size
        // whose upper half is ignored, then short vectors and a parameter
        opening = '{OP_XCOMPLETE, PING_RESET, OP_UNDEFINED_FE, OP_XSDRINC,
                    OP_XSDR, OP_XSETSDRMASKS, OP_XSIR, 8'h00,
                    OP_XSDRSIZE, 8'hFF, 8'hFF, 8'h00, 8'h09,
                    OP_XSDRTDO, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                    OP_XSIR, 8'h01, 8'h80, OP_XREPEAT, 8'h20};
        foreach (opening[i])
            send_byte(opening[i]);
        vec_bytes = 2;

        // XSDRINC as ping, ping 0 behind XCOMPLETE, ping on a standard code
        ping_plan = '{OP_XSDRINC, OP_XCOMPLETE, OP_XSDR, 8'($urandom), PING_RESET};
        foreach (ping_plan[i]) begin
            settle();
            ping_now = ping_plan[i];
            write_ping(ping_now);
            if (i == 0)
                long_hold_due = 1'b1;
            phase_end = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < phase_end)
                send_instruction(pick_opcode());
        end

        // the largest count the 16-bit size allows; only the head of the
        // vector goes out, the stream simply stops inside it
        send_byte(OP_XSDRSIZE);
        repeat (4) send_byte(8'hFF);
        vec_bytes = MAX_VECTOR_BYTES;
        send_byte(OP_XSDR);
        send_random(MAX_VEC_HEAD);
        settle();

        if (mismatches == 0)
            $display("xsvf_instruction_framer_test: done, clean");
        else
            $display("xsvf_instruction_framer_test: done, errors");
        $finish;
    end

endmodule
